[design/assert_macros.svh]
// Assertion macros shared by the RTL of the haptic PWM driver.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, off while reset is asserted.
`define ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[design/hdpwm_pkg.sv]
// Types, constants and duty/period functions of the haptic PWM driver.
// Used by every module of the block; depends on nothing else.
package hdpwm_pkg;

  localparam int DIST_W  = 8;   // width of one finger distance
  localparam int CHAN_W  = 6;   // width of duty, period and counter
  localparam int HAND_W  = 12;  // motor bits per hand
  localparam int OUT_W   = 32;  // result tdata, padded to whole bytes

  // Configuration register indexes.
  localparam logic REG_LEFT_ENABLE  = 1'b0;
  localparam logic REG_RIGHT_ENABLE = 1'b1;

  // Motor direction codes: bit 1 left motor, bit 0 right motor.
  localparam logic [1:0] DIR_NONE  = 2'b00;
  localparam logic [1:0] DIR_LEFT  = 2'b10;
  localparam logic [1:0] DIR_RIGHT = 2'b01;
  localparam logic [1:0] DIR_BOTH  = 2'b11;

  // Magnitude thresholds.
  localparam logic [7:0] MAG_OFF      = 8'd50;
  localparam logic [7:0] MAG_FAR_END  = 8'd88;

  // Fixed settings.
  localparam logic [CHAN_W-1:0] IDLE_DUTY     = 6'd4;
  localparam logic [CHAN_W-1:0] IDLE_PERIOD   = 6'd10;
  localparam logic [CHAN_W-1:0] WRIST_DUTY    = 6'd40;
  localparam logic [CHAN_W-1:0] WRIST_PERIOD  = 6'd60;
  localparam logic [CHAN_W-1:0] RESET_PERIOD  = 6'd20;

  // Fixed-point ramps, scaled by 2^12.
  localparam int DUTY_SLOPE   = 835;
  localparam int DUTY_BASE    = 40960;
  localparam int PERIOD_SLOPE = 417;
  localparam int PERIOD_BASE  = 102400;
  localparam int RAMP_W       = 17;
  localparam int FRAC_W       = 12;

  // Per-channel update for one step.
  typedef struct packed {
    logic [1:0]        dir;
    logic              load_dir;
    logic [CHAN_W-1:0] duty;
    logic [CHAN_W-1:0] period;
    logic              load_period;
  } chan_cmd_t;

  // Duty for a magnitude of one to 49, given the magnitude minus one.
  function automatic logic [CHAN_W-1:0] duty_ramp(input logic [CHAN_W-1:0] mm1);
    logic [RAMP_W-1:0] acc;
    acc = RAMP_W'(DUTY_SLOPE) * RAMP_W'(mm1) + RAMP_W'(DUTY_BASE);
    return CHAN_W'(acc >> FRAC_W);
  endfunction

  // Period for a magnitude of one to 49, given the magnitude minus one.
  function automatic logic [CHAN_W-1:0] period_ramp(input logic [CHAN_W-1:0] mm1);
    logic [RAMP_W-1:0] acc;
    acc = RAMP_W'(PERIOD_SLOPE) * RAMP_W'(mm1) + RAMP_W'(PERIOD_BASE);
    return CHAN_W'(acc >> FRAC_W);
  endfunction

endpackage

[design/haptic_distance_pwm_driver.sv]
// Top level of the haptic distance PWM driver: input register, finger
// decoders, twelve PWM channels, wrist rule and result register.
// Depends on hdpwm_pkg, hdpwm_finger_dec, hdpwm_channel and assert_macros.svh.
//
// Usage: each item on the s_axis channel is one tick carrying NUM_FINGERS
// signed 8-bit finger distances. For each accepted item the block updates
// the duty, period and direction of every finger channel and of the two
// wrist channels, then emits one result item on m_axis holding the motor
// bits of both hands and the two active-low output enables.
// The enables come from the write port: index 0 is left_enable, index 1 is
// right_enable, both reset to 1; only bit 0 of the data is kept.
// An accepted item lands in the input register, and its result is written
// to the output register once that register is empty or being taken.
// Throughput is one item per cycle while the receiver takes results, set
// by the single pass of decode and channel logic between the input and
// result registers.
// When the receiver stalls, the result stays put, the next item waits in
// the input register, and s_axis_tready drops only once both are full.
// Reset clears both valid flags, sets every period to 20, every counter to
// 0, the wrist directions to both motors and both enables to 1.
`include "assert_macros.svh"

module haptic_distance_pwm_driver #(
  parameter int NUM_FINGERS = 10
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // Configuration write port.
  input  logic                                        cfg_we_i,
  input  logic                                        cfg_idx_i,
  input  logic                                        cfg_data_i,
  // Input items. tdata: finger_distance_0 in [7:0] up to the last finger.
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  input  logic [hdpwm_pkg::DIST_W*NUM_FINGERS-1:0]    s_axis_tdata,
  // Result items. tdata: left_hand_bits [11:0], right_hand_bits [23:12],
  // left_output_enable_n [24], right_output_enable_n [25], zeros above.
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  output logic [hdpwm_pkg::OUT_W-1:0]                 m_axis_tdata
);

  localparam int Half  = NUM_FINGERS / 2;
  localparam int InW   = hdpwm_pkg::DIST_W * NUM_FINGERS;
  localparam int RightN = NUM_FINGERS - Half;

  // Handshake and input register.
  logic           s1_valid_q, s1_valid_d;
  logic [InW-1:0] s1_data_q;
  logic           out_valid_q, out_valid_d;
  logic [hdpwm_pkg::OUT_W-1:0] out_data_q;
  logic           step, in_fire;

  assign step          = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || step;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s1_valid_d    = in_fire || (s1_valid_q && !step);
  assign out_valid_d   = step || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= s_axis_tdata;
    end
  end

  // Configuration registers.
  logic left_en_q, right_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_en_q  <= 1'b1;
      right_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hdpwm_pkg::REG_LEFT_ENABLE:  left_en_q  <= cfg_data_i;
        hdpwm_pkg::REG_RIGHT_ENABLE: right_en_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Finger decoders.
  hdpwm_pkg::chan_cmd_t   fcmd [NUM_FINGERS];
  logic [NUM_FINGERS-1:0] far;

  for (genvar f = 0; f < NUM_FINGERS; f++) begin : g_dec
    hdpwm_finger_dec u_dec (
      .dist_i (s1_data_q[hdpwm_pkg::DIST_W*f +: hdpwm_pkg::DIST_W]),
      .cmd_o  (fcmd[f]),
      .far_o  (far[f])
    );
  end

  // Wrist rule: a hand whose fingers are all hovering far from their keys
  // gets a steady wrist cue in the thumb's direction.
  logic [3:0]           far_right_cnt;
  logic                 left_all_far, right_all_far;
  hdpwm_pkg::chan_cmd_t wl_cmd, wr_cmd;

  always_comb begin
    far_right_cnt = '0;
    for (int i = Half; i < NUM_FINGERS; i++) begin
      far_right_cnt = far_right_cnt + 4'(far[i]);
    end
  end

  assign left_all_far  = &far[Half-1:0];
  assign right_all_far = (far_right_cnt == 4'(Half)) && (RightN >= Half);

  always_comb begin
    wl_cmd.dir         = fcmd[Half-1].dir;
    wl_cmd.load_dir    = left_all_far;
    wl_cmd.duty        = left_all_far ? hdpwm_pkg::WRIST_DUTY : '0;
    wl_cmd.period      = hdpwm_pkg::WRIST_PERIOD;
    wl_cmd.load_period = left_all_far;
    wr_cmd.dir         = fcmd[Half].dir;
    wr_cmd.load_dir    = right_all_far;
    wr_cmd.duty        = right_all_far ? hdpwm_pkg::WRIST_DUTY : '0;
    wr_cmd.period      = hdpwm_pkg::WRIST_PERIOD;
    wr_cmd.load_period = right_all_far;
  end

  // PWM channels: one per finger shown on the outputs, plus the wrists.
  logic [1:0] lb [Half];
  logic [1:0] rb [Half];
  logic [1:0] wl_bits, wr_bits;

  for (genvar i = 0; i < Half; i++) begin : g_chan
    hdpwm_channel #(.RESET_DIR(hdpwm_pkg::DIR_NONE)) u_left (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (step),
      .cmd_i  (fcmd[i]),
      .bits_o (lb[i])
    );
    hdpwm_channel #(.RESET_DIR(hdpwm_pkg::DIR_NONE)) u_right (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (step),
      .cmd_i  (fcmd[i+Half]),
      .bits_o (rb[i])
    );
  end

  hdpwm_channel #(.RESET_DIR(hdpwm_pkg::DIR_BOTH)) u_wrist_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cmd_i  (wl_cmd),
    .bits_o (wl_bits)
  );

  hdpwm_channel #(.RESET_DIR(hdpwm_pkg::DIR_BOTH)) u_wrist_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cmd_i  (wr_cmd),
    .bits_o (wr_bits)
  );

  // Finger 0 of each hand sits in the top bit pair, the wrist in the bottom.
  logic [hdpwm_pkg::HAND_W-1:0] lbits, rbits;

  always_comb begin
    lbits = '0;
    rbits = '0;
    for (int i = 0; i < Half; i++) begin
      lbits[2*(Half-i) +: 2] = lb[i];
      rbits[2*(Half-i) +: 2] = rb[i];
    end
    lbits[1:0] = wl_bits;
    rbits[1:0] = wr_bits;
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= {6'b0, ~right_en_q, ~left_en_q, rbits, lbits};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Both stages full and the receiver stalled: no new item may enter.
  `ASSERT_IMPL(a_full_blocks_input, s1_valid_q && out_valid_q && !m_axis_tready,
    !s_axis_tready, "input accepted while both stages are full")
  // A taken result with nothing behind it leaves the output empty.
  `ASSERT_NEXT(a_drain_empties, out_valid_q && m_axis_tready && !s1_valid_q,
    !m_axis_tvalid, "result repeated after it was taken")
  // Without the far-hover condition the left wrist stays silent.
  `ASSERT_IMPL(a_wrist_left_quiet, step && !left_all_far, wl_bits == 2'b00,
    "left wrist driven while its hand is not hovering")

endmodule

[design/hdpwm_finger_dec.sv]
// Decoder from one signed finger distance to that finger's channel update.
// Depends on hdpwm_pkg.
module hdpwm_finger_dec (
  input  logic [hdpwm_pkg::DIST_W-1:0] dist_i,
  output hdpwm_pkg::chan_cmd_t         cmd_o,
  output logic                         far_o
);

  logic [7:0]                   mag;
  logic [hdpwm_pkg::CHAN_W-1:0] mm1;

  // A distance of -128 gives a magnitude of 128, which is simply off.
  assign mag = dist_i[7] ? (8'd0 - dist_i) : dist_i;
  assign mm1 = mag[hdpwm_pkg::CHAN_W-1:0] - 6'd1;
  assign far_o = (mag >= hdpwm_pkg::MAG_OFF) && (mag < hdpwm_pkg::MAG_FAR_END);

  always_comb begin
    cmd_o.load_dir = 1'b1;
    cmd_o.dir      = dist_i[7] ? hdpwm_pkg::DIR_RIGHT : hdpwm_pkg::DIR_LEFT;
    if (mag >= hdpwm_pkg::MAG_OFF) begin
      cmd_o.duty        = '0;
      cmd_o.period      = '0;
      cmd_o.load_period = 1'b0;
    end else if (mag != 8'd0) begin
      cmd_o.duty        = hdpwm_pkg::duty_ramp(mm1);
      cmd_o.period      = hdpwm_pkg::period_ramp(mm1);
      cmd_o.load_period = 1'b1;
    end else begin
      // On the key: gentle buzz on both motors.
      cmd_o.duty        = hdpwm_pkg::IDLE_DUTY;
      cmd_o.period      = hdpwm_pkg::IDLE_PERIOD;
      cmd_o.load_period = 1'b1;
      cmd_o.dir         = hdpwm_pkg::DIR_BOTH;
    end
  end

endmodule

[design/hdpwm_channel.sv]
// One soft-PWM motor pair: period, counter and direction registers.
// Depends on hdpwm_pkg.
module hdpwm_channel #(
  parameter logic [1:0] RESET_DIR = 2'b00
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  hdpwm_pkg::chan_cmd_t cmd_i,
  output logic [1:0]           bits_o
);

  logic [hdpwm_pkg::CHAN_W-1:0] period_q, period_d, counter_q, counter_d, count_inc;
  logic [1:0]                   dir_q, dir_d;

  assign dir_d    = cmd_i.load_dir ? cmd_i.dir : dir_q;
  assign period_d = cmd_i.load_period ? cmd_i.period : period_q;

  // The counter shown this step is the old one; duty and direction are new.
  assign bits_o    = (counter_q < cmd_i.duty) ? dir_d : 2'b00;
  assign count_inc = counter_q + 6'd1;
  assign counter_d = (count_inc > period_d) ? '0 : count_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= hdpwm_pkg::RESET_PERIOD;
      counter_q <= '0;
      dir_q     <= RESET_DIR;
    end else if (step_i) begin
      period_q  <= period_d;
      counter_q <= counter_d;
      dir_q     <= dir_d;
    end
  end

endmodule
